/* src/assert_macros.svh */
// shared assertion macros for the counted key table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that holds at every clock edge out of reset
`define CKT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// a condition that implies another in the same cycle
`define CKT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/ckt_pkg.sv */
package ckt_pkg;

    // default sizing of the table
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_KEY_BITS      = 16;
    localparam int DEF_COUNT_BITS    = 16;

    // fixed widths of the channel fields
    localparam int KIND_W         = 2;
    localparam int KEY_IN_W       = 16;
    localparam int COUNT_OUT_W    = 16;
    localparam int DISTINCT_OUT_W = 5;

    // request operation codes
    localparam logic [KIND_W-1:0] KIND_ADD       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DECREMENT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY     = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // latch a new request, clear search results
        logic issue;   // read the row at the scan index
        logic commit;  // write back and register the result
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic hit_found;  // the key has been located
        logic out_free;   // the result register can take a new result
    } status_t;

endpackage

/* src/ckt_req_if.sv */
interface ckt_req_if
    import ckt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_IN_W-1:0] item_key;

    modport source (output valid, output kind, output item_key, input ready);
    modport sink   (input valid, input kind, input item_key, output ready);
endinterface

/* src/ckt_rsp_if.sv */
interface ckt_rsp_if
    import ckt_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      success;
    logic [COUNT_OUT_W-1:0]    item_count;
    logic [DISTINCT_OUT_W-1:0] distinct_keys;
    logic                      table_full;

    modport source (output valid, output success, output item_count,
                    output distinct_keys, output table_full, input ready);
    modport sink   (input valid, input success, input item_count,
                    input distinct_keys, input table_full, output ready);
endinterface

/* src/ckt_ram.sv */
module ckt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* src/ckt_datapath.sv */
`include "assert_macros.svh"

module ckt_datapath
    import ckt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cmd_t                             cmd,
    output status_t                          status,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx,
    input  logic [KIND_W-1:0]                req_kind,
    input  logic [KEY_IN_W-1:0]              req_key,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output logic                             rsp_success,
    output logic [COUNT_OUT_W-1:0]           rsp_item_count,
    output logic [DISTINCT_OUT_W-1:0]        rsp_distinct_keys,
    output logic                             rsp_table_full
);
    localparam int IDX_W     = $clog2(TABLE_ENTRIES);
    localparam int OCC_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W     = KEY_BITS + COUNT_BITS;
    localparam int KEY_EXT_W = (KEY_BITS > KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int CNT_EXT_W = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
    localparam int OCC_EXT_W = (OCC_W > DISTINCT_OUT_W) ? OCC_W : DISTINCT_OUT_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // request registers
    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_EXT_W-1:0] key_ext;
    logic [KEY_BITS-1:0] key_in;

    // search pipeline and results
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  hit_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [COUNT_BITS-1:0] hit_cnt_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    // table state
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [OCC_W-1:0]         occ_reg;
    logic [OCC_W-1:0]         occ_next;

    // row storage
    logic                  ram_we;
    logic [ROW_W-1:0]      ram_wdata;
    logic [ROW_W-1:0]      ram_rdata;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  row_match;
    logic                  row_free;

    // update decision
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic                  set_valid;
    logic                  clr_valid;
    logic                  occ_inc;
    logic                  occ_dec;
    logic                  res_ok;
    logic [COUNT_BITS-1:0] res_cnt;
    logic                  res_full;
    logic [CNT_EXT_W-1:0]  res_cnt_ext;
    logic [OCC_EXT_W-1:0]  occ_ext;

    // result register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      out_success_reg;
    logic [COUNT_OUT_W-1:0]    out_count_reg;
    logic [DISTINCT_OUT_W-1:0] out_distinct_reg;
    logic                      out_full_reg;

    // key narrowed or widened to the table key width
    assign key_ext = KEY_EXT_W'(req_key);
    assign key_in  = key_ext[KEY_BITS-1:0];

    ckt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx),
        .wdata (ram_wdata),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[ROW_W-1:COUNT_BITS];
    assign rd_cnt    = ram_rdata[COUNT_BITS-1:0];
    assign row_match = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_key == key_reg);
    assign row_free  = cmp_vld_reg && !valid_reg[cmp_idx_reg];

    // scan bookkeeping, cleared when a new request is latched
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.issue;
            if (cmd.load)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (row_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (row_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // request latch and payload side of the scan
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_idx;
        if (cmd.load)
        begin
            kind_reg <= req_kind;
            key_reg  <= key_in;
        end
        if (!cmd.load && row_match && !hit_found_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_cnt_reg <= rd_cnt;
        end
        if (!cmd.load && row_free && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // operation decode
    always_comb
    begin
        wr_en     = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_cnt    = hit_cnt_reg;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        occ_inc   = 1'b0;
        occ_dec   = 1'b0;
        res_ok    = 1'b0;
        res_cnt   = '0;
        res_full  = 1'b0;
        case (kind_reg)
            KIND_ADD:
            begin
                if (hit_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_cnt  = (hit_cnt_reg == COUNT_MAX) ? hit_cnt_reg
                                                         : hit_cnt_reg + COUNT_BITS'(1);
                    res_ok  = 1'b1;
                    res_cnt = wr_cnt;
                end
                else if (free_found_reg)
                begin
                    wr_en     = 1'b1;
                    wr_idx    = free_idx_reg;
                    wr_cnt    = COUNT_BITS'(1);
                    set_valid = 1'b1;
                    occ_inc   = 1'b1;
                    res_ok    = 1'b1;
                    res_cnt   = COUNT_BITS'(1);
                end
                else
                begin
                    res_full = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (hit_found_reg)
                begin
                    clr_valid = 1'b1;
                    occ_dec   = 1'b1;
                    res_ok    = 1'b1;
                end
            end
            KIND_DECREMENT:
            begin
                if (hit_found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_cnt  = (hit_cnt_reg != '0) ? hit_cnt_reg - COUNT_BITS'(1) : '0;
                    res_ok  = 1'b1;
                    res_cnt = wr_cnt;
                    if (wr_cnt == '0)
                    begin
                        clr_valid = 1'b1;
                        occ_dec   = 1'b1;
                    end
                end
            end
            KIND_QUERY:
            begin
                if (hit_found_reg)
                begin
                    res_ok  = 1'b1;
                    res_cnt = hit_cnt_reg;
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    assign ram_we    = cmd.commit && wr_en;
    assign ram_wdata = {key_reg, wr_cnt};

    // valid bits and occupancy
    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (cmd.commit)
        begin
            if (set_valid)
            begin
                valid_next[free_idx_reg] = 1'b1;
            end
            if (clr_valid)
            begin
                valid_next[hit_idx_reg] = 1'b0;
            end
            if (occ_inc)
            begin
                occ_next = occ_reg + OCC_W'(1);
            end
            if (occ_dec)
            begin
                occ_next = occ_reg - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    // result register
    assign res_cnt_ext    = CNT_EXT_W'(res_cnt);
    assign occ_ext        = OCC_EXT_W'(occ_next);
    assign out_valid_next = cmd.commit ? 1'b1
                          : (out_valid_reg && rsp_ready) ? 1'b0 : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_success_reg  <= res_ok;
            out_count_reg    <= res_cnt_ext[COUNT_OUT_W-1:0];
            out_distinct_reg <= occ_ext[DISTINCT_OUT_W-1:0];
            out_full_reg     <= res_full;
        end
    end

    assign rsp_valid         = out_valid_reg;
    assign rsp_success       = out_success_reg;
    assign rsp_item_count    = out_count_reg;
    assign rsp_distinct_keys = out_distinct_reg;
    assign rsp_table_full    = out_full_reg;

    assign status.hit_found = hit_found_reg;
    assign status.out_free  = !out_valid_reg || rsp_ready;

    // checks
    `CKT_ASSERT_ALWAYS(a_occ_matches_valid, $countones(valid_reg) == int'(occ_reg), "occupancy count disagrees with valid bits")
    `CKT_ASSERT_IMPLIES(a_commit_needs_slot, cmd.commit, !out_valid_reg || rsp_ready, "result written over one not yet taken")
    `CKT_ASSERT_IMPLIES(a_hit_from_compare, $rose(hit_found_reg), $past(cmp_vld_reg), "hit recorded without a row compare")
endmodule

/* src/ckt_controller.sv */
module ckt_controller
    import ckt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  status_t                          status,
    output cmd_t                             cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    // sequencing of one request: scan rows, write back, hand over result
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.hit_found)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign scan_idx = idx_reg;
endmodule

/* src/counted_key_table_core.sv */
// counted key table: a small associative table of key to count
// requests arrive on req (kind, item_key); one result per request leaves
// on rsp (success, item_count, distinct_keys, table_full); a transaction
// completes at a clock edge with valid and ready both high
// each request scans the stored rows one per cycle through the single read
// port of the row memory, stopping once the key is found
// one request is worked on at a time; req ready is high only between
// requests, so none is taken before the last one is written back
// the result sits in an output register; a new request may be taken while
// it waits, but its write-back holds off until the old result is taken
// when rsp stalls the result and all table state hold unchanged
// reset clears the valid bits and the key count at once; no clearing pass
// is needed, keys and counts of free rows are never used
module counted_key_table_core
    import ckt_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    ckt_req_if.sink   req,
    ckt_rsp_if.source rsp
);
    cmd_t                             cmd;
    status_t                          status;
    logic [$clog2(TABLE_ENTRIES)-1:0] scan_idx;

    // request sequencer
    ckt_controller #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd),
        .scan_idx  (scan_idx)
    );

    // table storage, compare and update
    ckt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .scan_idx          (scan_idx),
        .req_kind          (req.kind),
        .req_key           (req.item_key),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_success       (rsp.success),
        .rsp_item_count    (rsp.item_count),
        .rsp_distinct_keys (rsp.distinct_keys),
        .rsp_table_full    (rsp.table_full)
    );
endmodule
